// ----- sv/teq_pkg.sv -----
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types for the timer expiry queue: result codes, controller states,
// and the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package teq_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_POPPED   = 2'd2,
		ST_NONE     = 2'd3
	} status_t;

	// Request kinds
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_POLL   = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_POLL_CMP,
		S_FIN
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic    in_ready;
		logic    load_req;
		logic    k_load;
		logic    k_dec;
		logic    rd_en;
		logic    rd_prev;
		logic    wr_en;
		logic    wr_new;
		logic    pop;
		logic    set_res;
		status_t res_code;
		logic    load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_valid;
		logic req_poll;
		logic full;
		logic empty;
		logic k_zero;
		logic rd_gt;
		logic due;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ----- sv/teq_req_if.sv -----
// ----------------------------------------------------------------------------
// teq_req_if
// Request channel: insert or poll words with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface teq_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [63:0] due_time;
	logic [15:0] msg_handle;
	logic [63:0] now_time;

	modport source (output valid, req_type, due_time, msg_handle, now_time,
		input ready);
	modport sink (input valid, req_type, due_time, msg_handle, now_time,
		output ready);
endinterface

`default_nettype wire

// ----- sv/teq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// teq_rsp_if
// Response channel: one result word per request, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface teq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] out_handle;
	logic [63:0] out_time;
	logic [6:0]  entry_count;

	modport source (output valid, status, out_handle, out_time, entry_count,
		input ready);
	modport sink (input valid, status, out_handle, out_time, entry_count,
		output ready);
endinterface

`default_nettype wire

// ----- sv/timer_expiry_priority_queue.sv -----
// ----------------------------------------------------------------------------
// timer_expiry_priority_queue
// Timer queue ordered by trigger time, earliest first, first-in among equals.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | req_type, due_time, msg_handle, now_time
//  rsp     | out | valid / ready | status, out_handle, out_time, entry_count
//
// One request at a time. A poll reads the head and compares it with the
// request's now time; a rejected insert or empty poll goes straight to its
// result word. An insert moves every stored entry later than the new time
// up one place, from the tail down, then writes the new entry; the entry
// RAM moves one entry per read/compare-write pair.
// Reset clears count and head pointer; RAM contents need no clearing.
// A stalled result word holds in the output register; the block waits there.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_expiry_priority_queue #(
	parameter int CAPACITY    = 64,
	parameter int HANDLE_BITS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	teq_req_if.sink   req,
	teq_rsp_if.source rsp
);
	import teq_pkg::*;

	cmd_t  cmd;
	stat_t st;

	teq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.st    (st),
		.cmd   (cmd)
	);

	teq_dp #(.CAPACITY(CAPACITY), .HANDLE_BITS(HANDLE_BITS)) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cmd   (cmd),
		.st    (st)
	);

endmodule

`default_nettype wire

// ----- sv/teq_ram.sv -----
// ----------------------------------------------------------------------------
// teq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module teq_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/teq_ctrl.sv -----
// ----------------------------------------------------------------------------
// teq_ctrl
// Sequencer for the timer queue: accepts a request, walks the insert shift
// one entry per read and compare-write state pair, checks the head on a
// poll, then hands the result word to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module teq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire teq_pkg::stat_t st,
	output teq_pkg::cmd_t       cmd
);
	import teq_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.res_code = ST_NONE;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (st.in_valid) begin
					cmd.load_req = 1'b1;
					if (st.req_poll) begin
						if (st.empty) begin
							cmd.set_res = 1'b1;
							cmd.res_code = ST_NONE;
							state_d = S_FIN;
						end else begin
							cmd.rd_en = 1'b1;
							state_d = S_POLL_CMP;
						end
					end else begin
						if (st.full) begin
							cmd.set_res = 1'b1;
							cmd.res_code = ST_FULL;
							state_d = S_FIN;
						end else begin
							cmd.k_load = 1'b1;
							state_d = S_INS_RD;
						end
					end
				end
			end
			S_INS_RD: begin
				if (st.k_zero) begin
					cmd.wr_en = 1'b1;
					cmd.wr_new = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res_code = ST_INSERTED;
					state_d = S_FIN;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_prev = 1'b1;
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				cmd.wr_en = 1'b1;
				if (st.rd_gt) begin
					cmd.k_dec = 1'b1;
					state_d = S_INS_RD;
				end else begin
					cmd.wr_new = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res_code = ST_INSERTED;
					state_d = S_FIN;
				end
			end
			S_POLL_CMP: begin
				cmd.set_res = 1'b1;
				if (st.due) begin
					cmd.pop = 1'b1;
					cmd.res_code = ST_POPPED;
				end else begin
					cmd.res_code = ST_NONE;
				end
				state_d = S_FIN;
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_fin_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && st.out_free) |=> state_q == S_IDLE)
		else $error("result not handed off");
	a_ins_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_CMP && st.rd_gt) |=> state_q == S_INS_RD)
		else $error("insert shift did not continue");
	a_poll_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POLL_CMP |-> $past(cmd.rd_en))
		else $error("poll compare without head read");
`endif

endmodule

`default_nettype wire

// ----- sv/teq_dp.sv -----
// ----------------------------------------------------------------------------
// teq_dp
// Datapath: entry RAM kept sorted as a ring from a head pointer, request
// holding registers, shift index, count and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module teq_dp #(
	parameter int CAPACITY    = 64,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	teq_req_if.sink            req,
	teq_rsp_if.source          rsp,
	input  wire teq_pkg::cmd_t cmd,
	output teq_pkg::stat_t     st
);
	import teq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int HS = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
	localparam int DW = 64 + HS;

	logic [63:0]   t_q;
	logic [HS-1:0] h_q;
	logic [63:0]   now_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;

	status_t       res_status_q;
	logic [HS-1:0] res_handle_q;
	logic [63:0]   res_time_q;

	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [15:0]   out_handle_q;
	logic [63:0]   out_time_q;
	logic [6:0]    out_count_q;

	logic [DW-1:0] rdata;
	logic [DW-1:0] wdata;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [63:0]   rd_time;
	logic [HS-1:0] rd_handle;
	logic [CW-1:0] k_prev;
	logic [CW+6:0] count_ext;

	// Map a logical position to a ring address
	function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
		input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(pos);
		if (sum >= (CW+1)'(CAPACITY)) begin
			sum = sum - (CW+1)'(CAPACITY);
		end
		return sum[AW-1:0];
	endfunction

	assign rd_time   = rdata[DW-1:HS];
	assign rd_handle = rdata[HS-1:0];
	assign k_prev    = k_q - CW'(1);
	assign raddr     = cmd.rd_prev ? ring_addr(head_q, k_prev) : head_q;
	assign waddr     = ring_addr(head_q, k_q);
	assign wdata     = cmd.wr_new ? {t_q, h_q} : rdata;

	teq_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Status toward the controller
	always_comb begin
		st.in_valid = req.valid;
		st.req_poll = (req.req_type == REQ_POLL);
		st.full     = (count_q == CW'(CAPACITY));
		st.empty    = (count_q == '0);
		st.k_zero   = (k_q == '0);
		st.rd_gt    = (rd_time > t_q);
		st.due      = (now_q >= rd_time);
		st.out_free = !out_valid_q || rsp.ready;
	end

	assign req.ready = cmd.in_ready;

	// Hold request fields
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			t_q   <= req.due_time;
			h_q   <= req.msg_handle[HS-1:0];
			now_q <= req.now_time;
		end
	end

	// Shift index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.k_load) begin
			k_q <= count_q;
		end else if (cmd.k_dec) begin
			k_q <= k_prev;
		end
	end

	// Count and head pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
		end else if (cmd.wr_new) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CW'(1);
			if (head_q == AW'(CAPACITY - 1)) begin
				head_q <= '0;
			end else begin
				head_q <= head_q + AW'(1);
			end
		end
	end

	// Capture the result
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			if (cmd.pop) begin
				res_handle_q <= rd_handle;
				res_time_q   <= rd_time;
			end else begin
				res_handle_q <= '0;
				res_time_q   <= '0;
			end
		end
	end

	assign count_ext = (CW+7)'(count_q);

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_handle_q <= 16'(res_handle_q);
			out_time_q   <= res_time_q;
			out_count_q  <= count_ext[6:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.out_handle  = out_handle_q;
	assign rsp.out_time    = out_time_q;
	assign rsp.entry_count = out_count_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not drop count");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> k_q <= count_q)
		else $error("shift index past count");
`endif

endmodule

`default_nettype wire
